/* sv/x509_tbs_pkg.sv */
// -----------------------------------------------------------------------------
// X.509 TBS header parser package
// Parse phase codes, result kinds and DER constants shared by the parser.
// -----------------------------------------------------------------------------
package x509_tbs_pkg;

   // Long-form lengths may use from one up to this many octets (range 1 to 4).
   localparam int MAX_LENGTH_OCTETS = 2;

   localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
   localparam logic [7:0] TAG_CTX0       = 8'hA0;
   localparam logic [7:0] VER_WRAP_LEN   = 8'h03;
   localparam logic [7:0] TAG_INTEGER    = 8'h02;
   localparam logic [7:0] TAG_OID        = 8'h06;
   localparam logic [7:0] TAG_NULL       = 8'h05;
   localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;
   localparam logic [7:0] VER_INT_LEN    = 8'h01;
   localparam logic [7:0] NULL_LEN       = 8'h00;

   typedef enum logic [22:0] {
      PH_IDLE       = 23'h000001,
      PH_OUT_LEN    = 23'h000002,
      PH_OUT_LENX   = 23'h000004,
      PH_TBS_TAG    = 23'h000008,
      PH_TBS_LEN    = 23'h000010,
      PH_TBS_LENX   = 23'h000020,
      PH_VER_TAG    = 23'h000040,
      PH_VER_LEN    = 23'h000080,
      PH_VER_INT    = 23'h000100,
      PH_VER_ILEN   = 23'h000200,
      PH_VER_VAL    = 23'h000400,
      PH_SER_TAG    = 23'h000800,
      PH_SER_LEN    = 23'h001000,
      PH_SER_BYTES  = 23'h002000,
      PH_ALG_TAG    = 23'h004000,
      PH_ALG_LEN    = 23'h008000,
      PH_ALG_LENX   = 23'h010000,
      PH_ALG_BODY   = 23'h020000,
      PH_OID_LEN    = 23'h040000,
      PH_OID_BYTES  = 23'h080000,
      PH_AFTER_OID  = 23'h100000,
      PH_NULL_LEN   = 23'h200000,
      PH_ISSUER_TAG = 23'h400000
   } phase_type;

   typedef enum logic [2:0] {
      KIND_VERSION = 3'd0,
      KIND_SERIAL  = 3'd1,
      KIND_OID     = 3'd2,
      KIND_ACCEPT  = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

endpackage

/* sv/x509_tbs_header_parser.sv */
// -----------------------------------------------------------------------------
// X.509 TBS header parser
// Streams a DER certificate byte by byte, checks the head of the TBS part and
// reports the version, serial bytes, signature OID bytes, acceptance or error.
// -----------------------------------------------------------------------------
//  channel | direction | tdata             | tuser                  | tlast
//  req     | in        | [7:0] data_byte   | start_of_certificate   | -
//  rsp     | out       | [7:0] field_value | [2:0] field_kind       | last_of_field
//
// One byte per cycle while the response side does not stall: a beat is
// registered at the input, then one state transition of the parser writes the result register.
// Any byte that produces no result leaves the pipe without a response beat.
// Reset puts the parser in the idle phase and empties both registers.
// A stalled response only holds the input side once the input register is
// also full and its byte would produce a result.
// -----------------------------------------------------------------------------
module x509_tbs_header_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] start_of_certificate
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] field_value
   output logic [2:0] rsp_tuser,   // [2:0] field_kind
   output logic       rsp_tlast    // last_of_field
);

   // Input register.
   logic       in_vld_ff;
   logic       in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // Parser state.
   x509_tbs_pkg::phase_type phase_ff;
   x509_tbs_pkg::phase_type phase_in;
   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic [1:0]  oct_left_ff;
   logic [1:0]  oct_left_in;
   logic [7:0]  field_left_ff;
   logic [7:0]  field_left_in;

   // Result register.
   logic                   out_vld_ff;
   logic                   out_vld_in;
   logic [7:0]             out_value_ff;
   x509_tbs_pkg::kind_type out_kind_ff;
   logic                   out_last_ff;

   logic                   res_vld;
   x509_tbs_pkg::kind_type res_kind;
   logic [7:0]             res_value;
   logic                   res_last;

   logic go;
   logic out_free;

   // Length octet decode.
   logic [6:0]  len_n;
   logic        len_long;
   logic        len_n_bad;
   logic [1:0]  len_left_first;
   logic [15:0] acc_more;

   assign out_free  = !out_vld_ff || rsp_tready;
   assign go        = in_vld_ff && (out_free || !res_vld);
   assign req_tready = !in_vld_ff || go;

   assign len_long       = in_byte_ff[7];
   assign len_n          = in_byte_ff[6:0];
   assign len_n_bad      = (len_n == 7'd0) ||
                           (len_n > 7'(x509_tbs_pkg::MAX_LENGTH_OCTETS));
   assign len_left_first = 2'(len_n - 7'd1);
   // Further long-form octets shift in big-endian and saturate at all ones.
   assign acc_more       = (acc_ff[15:8] != 8'd0) ? 16'hFFFF : {acc_ff[7:0], in_byte_ff};

   always_comb begin
      logic ok;
      ok            = 1'b1;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      oct_left_in   = oct_left_ff;
      field_left_in = field_left_ff;
      res_vld       = 1'b0;
      res_kind      = x509_tbs_pkg::KIND_ERROR;
      res_value     = 8'd0;
      res_last      = 1'b0;

      if (in_start_ff) begin
         phase_in      = x509_tbs_pkg::PH_IDLE;
         acc_in        = 16'd0;
         oct_left_in   = 2'd0;
         field_left_in = 8'd0;
         if (in_byte_ff == x509_tbs_pkg::TAG_SEQUENCE) begin
            phase_in = x509_tbs_pkg::PH_OUT_LEN;
         end else begin
            res_vld = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            x509_tbs_pkg::PH_OUT_LEN, x509_tbs_pkg::PH_TBS_LEN,
            x509_tbs_pkg::PH_ALG_LEN: begin
               if (!len_long) begin
                  if (phase_ff != x509_tbs_pkg::PH_ALG_LEN && in_byte_ff == 8'd0) begin
                     ok = 1'b0;
                  end
                  acc_in = {8'd0, in_byte_ff};
                  phase_in = (phase_ff == x509_tbs_pkg::PH_OUT_LEN) ? x509_tbs_pkg::PH_TBS_TAG :
                             (phase_ff == x509_tbs_pkg::PH_TBS_LEN) ? x509_tbs_pkg::PH_VER_TAG :
                                                                       x509_tbs_pkg::PH_ALG_BODY;
               end else if (len_n_bad) begin
                  ok = 1'b0;
               end else begin
                  acc_in      = 16'd0;
                  oct_left_in = len_left_first;
                  phase_in = (phase_ff == x509_tbs_pkg::PH_OUT_LEN) ? x509_tbs_pkg::PH_OUT_LENX :
                             (phase_ff == x509_tbs_pkg::PH_TBS_LEN) ? x509_tbs_pkg::PH_TBS_LENX :
                                                                       x509_tbs_pkg::PH_ALG_LENX;
               end
            end
            x509_tbs_pkg::PH_OUT_LENX, x509_tbs_pkg::PH_TBS_LENX,
            x509_tbs_pkg::PH_ALG_LENX: begin
               acc_in = acc_more;
               if (oct_left_ff == 2'd0) begin
                  if (phase_ff != x509_tbs_pkg::PH_ALG_LENX && acc_more == 16'd0) begin
                     ok = 1'b0;
                  end
                  phase_in = (phase_ff == x509_tbs_pkg::PH_OUT_LENX) ? x509_tbs_pkg::PH_TBS_TAG :
                             (phase_ff == x509_tbs_pkg::PH_TBS_LENX) ? x509_tbs_pkg::PH_VER_TAG :
                                                                        x509_tbs_pkg::PH_ALG_BODY;
               end else begin
                  oct_left_in = oct_left_ff - 2'd1;
               end
            end
            x509_tbs_pkg::PH_TBS_TAG: begin
               ok       = (in_byte_ff == x509_tbs_pkg::TAG_SEQUENCE);
               phase_in = x509_tbs_pkg::PH_TBS_LEN;
            end
            x509_tbs_pkg::PH_VER_TAG: begin
               ok       = (in_byte_ff == x509_tbs_pkg::TAG_CTX0);
               phase_in = x509_tbs_pkg::PH_VER_LEN;
            end
            x509_tbs_pkg::PH_VER_LEN: begin
               ok       = (in_byte_ff == x509_tbs_pkg::VER_WRAP_LEN);
               phase_in = x509_tbs_pkg::PH_VER_INT;
            end
            x509_tbs_pkg::PH_VER_INT: begin
               ok       = (in_byte_ff == x509_tbs_pkg::TAG_INTEGER);
               phase_in = x509_tbs_pkg::PH_VER_ILEN;
            end
            x509_tbs_pkg::PH_VER_ILEN: begin
               ok       = (in_byte_ff == x509_tbs_pkg::VER_INT_LEN);
               phase_in = x509_tbs_pkg::PH_VER_VAL;
            end
            x509_tbs_pkg::PH_VER_VAL: begin
               phase_in  = x509_tbs_pkg::PH_SER_TAG;
               res_vld   = 1'b1;
               res_kind  = x509_tbs_pkg::KIND_VERSION;
               res_value = in_byte_ff;
            end
            x509_tbs_pkg::PH_SER_TAG: begin
               ok       = (in_byte_ff == x509_tbs_pkg::TAG_INTEGER);
               phase_in = x509_tbs_pkg::PH_SER_LEN;
            end
            x509_tbs_pkg::PH_SER_LEN, x509_tbs_pkg::PH_OID_LEN: begin
               // Only a nonzero short-form length is allowed here.
               ok            = (in_byte_ff != 8'd0) && !in_byte_ff[7];
               field_left_in = in_byte_ff;
               phase_in      = (phase_ff == x509_tbs_pkg::PH_SER_LEN) ?
                               x509_tbs_pkg::PH_SER_BYTES : x509_tbs_pkg::PH_OID_BYTES;
            end
            x509_tbs_pkg::PH_SER_BYTES, x509_tbs_pkg::PH_OID_BYTES: begin
               res_vld   = 1'b1;
               res_kind  = (phase_ff == x509_tbs_pkg::PH_SER_BYTES) ?
                           x509_tbs_pkg::KIND_SERIAL : x509_tbs_pkg::KIND_OID;
               res_value = in_byte_ff;
               res_last  = (field_left_ff <= 8'd1);
               if (field_left_ff <= 8'd1) begin
                  field_left_in = 8'd0;
                  phase_in      = (phase_ff == x509_tbs_pkg::PH_SER_BYTES) ?
                                  x509_tbs_pkg::PH_ALG_TAG : x509_tbs_pkg::PH_AFTER_OID;
               end else begin
                  field_left_in = field_left_ff - 8'd1;
               end
            end
            x509_tbs_pkg::PH_ALG_TAG: begin
               ok       = (in_byte_ff == x509_tbs_pkg::TAG_SEQUENCE);
               phase_in = x509_tbs_pkg::PH_ALG_LEN;
            end
            x509_tbs_pkg::PH_ALG_BODY, x509_tbs_pkg::PH_AFTER_OID: begin
               if (in_byte_ff == x509_tbs_pkg::TAG_OID &&
                   phase_ff == x509_tbs_pkg::PH_ALG_BODY) begin
                  phase_in = x509_tbs_pkg::PH_OID_LEN;
               end else if (in_byte_ff == x509_tbs_pkg::TAG_NULL) begin
                  phase_in = x509_tbs_pkg::PH_NULL_LEN;
               end else if (in_byte_ff == x509_tbs_pkg::TAG_SEQUENCE) begin
                  phase_in      = x509_tbs_pkg::PH_IDLE;
                  acc_in        = 16'd0;
                  oct_left_in   = 2'd0;
                  field_left_in = 8'd0;
                  res_vld       = 1'b1;
                  res_kind      = x509_tbs_pkg::KIND_ACCEPT;
               end else begin
                  ok = 1'b0;
               end
            end
            x509_tbs_pkg::PH_NULL_LEN: begin
               ok       = (in_byte_ff == x509_tbs_pkg::NULL_LEN);
               phase_in = x509_tbs_pkg::PH_ISSUER_TAG;
            end
            x509_tbs_pkg::PH_ISSUER_TAG: begin
               if (in_byte_ff == x509_tbs_pkg::TAG_SEQUENCE) begin
                  phase_in      = x509_tbs_pkg::PH_IDLE;
                  acc_in        = 16'd0;
                  oct_left_in   = 2'd0;
                  field_left_in = 8'd0;
                  res_vld       = 1'b1;
                  res_kind      = x509_tbs_pkg::KIND_ACCEPT;
               end else begin
                  ok = 1'b0;
               end
            end
            default: begin
               // Idle bytes without a start flag are dropped.
               phase_in = x509_tbs_pkg::PH_IDLE;
            end
         endcase

         if (!ok) begin
            phase_in      = x509_tbs_pkg::PH_IDLE;
            acc_in        = 16'd0;
            oct_left_in   = 2'd0;
            field_left_in = 8'd0;
            res_vld       = 1'b1;
            res_kind      = x509_tbs_pkg::KIND_ERROR;
            res_value     = 8'd0;
            res_last      = 1'b0;
         end
      end
   end

   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !go);
   assign out_vld_in = (go && res_vld) || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         phase_ff      <= x509_tbs_pkg::PH_IDLE;
         acc_ff        <= 16'd0;
         oct_left_ff   <= 2'd0;
         field_left_ff <= 8'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (go) begin
            phase_ff      <= phase_in;
            acc_ff        <= acc_in;
            oct_left_ff   <= oct_left_in;
            field_left_ff <= field_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (go && res_vld) begin
         out_value_ff <= res_value;
         out_kind_ff  <= res_kind;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // A field byte count of zero inside the byte phases is flagged as an error.
   a_field_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == x509_tbs_pkg::PH_SER_BYTES || phase_ff == x509_tbs_pkg::PH_OID_BYTES)
      |-> field_left_ff != 8'd0)
      else $error("field byte count is zero inside a field");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
      (rsp_tuser == x509_tbs_pkg::KIND_SERIAL || rsp_tuser == x509_tbs_pkg::KIND_OID))
      else $error("last flag on a beat that is not a field byte");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid &&
      (rsp_tuser == x509_tbs_pkg::KIND_ACCEPT || rsp_tuser == x509_tbs_pkg::KIND_ERROR)
      |-> rsp_tdata == 8'd0)
      else $error("status beat carries a nonzero value");

   // Accept and error both end the parse.
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      go && res_vld &&
      (res_kind == x509_tbs_pkg::KIND_ACCEPT || res_kind == x509_tbs_pkg::KIND_ERROR)
      |=> phase_ff == x509_tbs_pkg::PH_IDLE)
      else $error("parser did not return to idle after a status beat");

endmodule
